[hw/rtl/dphc_pkg.sv]
package dphc_pkg;

	// Field and register widths
	localparam int ADC_BITS   = 12;
	localparam int TICK_BITS  = 16;
	localparam int CMD_W      = 2;
	localparam int MODE_W     = 3;
	localparam int DUTY_W     = 7;
	localparam int SDRV_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 32;
	localparam int DIV_CNT_W  = $clog2(ADC_BITS + 1);

	// Command codes (s_tuser)
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

	// Drive mode codes
	localparam logic [MODE_W-1:0] MODE_UNCHANGED = 3'd0;
	localparam logic [MODE_W-1:0] MODE_COAST     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BRAKE     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FORWARD   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REVERSE   = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ERR_DIV    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_TICKS  = 3'd6;

	// Register reset values
	localparam logic [ADC_BITS-1:0]  RST_SETPOINT   = 12'd2600;
	localparam logic [ADC_BITS-1:0]  RST_DEADBAND   = 12'd60;
	localparam logic [DUTY_W-1:0]    RST_MIN_DUTY   = 7'd20;
	localparam logic [DUTY_W-1:0]    RST_MAX_DUTY   = 7'd60;
	localparam logic [ADC_BITS-1:0]  RST_ERR_DIV    = 12'd16;
	localparam logic [TICK_BITS-1:0] RST_HOLD_DELAY = 16'd200;
	localparam logic [TICK_BITS-1:0] RST_RUN_TICKS  = 16'd2000;

	localparam logic [DUTY_W-1:0] DUTY_LIMIT = 7'd100;

endpackage

[hw/rtl/dphc_div.sv]
// Restoring divider, one quotient bit per cycle.
module dphc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dphc_pkg::ADC_BITS-1:0] dividend,
	input  logic [dphc_pkg::ADC_BITS-1:0] divisor,
	output logic                          done,
	output logic [dphc_pkg::ADC_BITS-1:0] quotient
);

	logic [dphc_pkg::ADC_BITS-1:0]  rem_q;
	logic [dphc_pkg::ADC_BITS-1:0]  quo_q;
	logic [dphc_pkg::ADC_BITS-1:0]  dvs_q;
	logic [dphc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [dphc_pkg::ADC_BITS:0]    shifted;
	logic [dphc_pkg::ADC_BITS:0]    trial;
	logic                           fits;

	always_comb begin
		shifted = {rem_q, quo_q[dphc_pkg::ADC_BITS-1]};
		trial   = shifted - {1'b0, dvs_q};
		fits    = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				// a zero divisor acts as one
				dvs_q  <= (divisor == '0) ? dphc_pkg::ADC_BITS'(1) : divisor;
				cnt_q  <= dphc_pkg::DIV_CNT_W'(dphc_pkg::ADC_BITS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? trial[dphc_pkg::ADC_BITS-1:0]
				              : shifted[dphc_pkg::ADC_BITS-1:0];
				quo_q <= {quo_q[dphc_pkg::ADC_BITS-2:0], fits};
				cnt_q <= cnt_q - dphc_pkg::DIV_CNT_W'(1);
				if (cnt_q == dphc_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hw/rtl/deadband_position_hold_controller.sv]
// Channel  | Group             | Contents
// ---------+-------------------+-----------------------------------------------
// input    | s_tvalid/s_tready | s_tuser: cmd; s_tdata: position
// result   | m_tvalid/m_tready | m_tdata: drive_mode, duty, signed_drive,
//          |                   |          target, run_active, run_done
// config   | cfg_we            | cfg_index selects register, cfg_data value
//
// A tick that drives the motor also passes through the divide state between accepts;
// the 12-step divider (|error| / error_divisor) runs while the sequencer waits there.
// Start, stop, coast, brake and idle items skip the divide state.
// Reset (arst_n low) restores register defaults and clears all run state.
// A result waits in the output register; the next item is taken meanwhile,
// and only the finish step of that next item stalls until the slot is free.
module deadband_position_hold_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dphc_pkg::S_TDATA_W-1:0]      s_tdata,  // [11:0] position
	input  logic [dphc_pkg::CMD_W-1:0]          s_tuser,  // [1:0] cmd
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [2:0] drive_mode, [9:3] duty, [17:10] signed_drive,
	// [29:18] target, [30] run_active, [31] run_done
	output logic [dphc_pkg::M_TDATA_W-1:0]      m_tdata,
	input  logic                                cfg_we,
	input  logic [dphc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dphc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [dphc_pkg::ADC_BITS-1:0]  setpoint_q;
	logic [dphc_pkg::ADC_BITS-1:0]  deadband_q;
	logic [dphc_pkg::DUTY_W-1:0]    min_duty_q;
	logic [dphc_pkg::DUTY_W-1:0]    max_duty_q;
	logic [dphc_pkg::ADC_BITS-1:0]  err_div_q;
	logic [dphc_pkg::TICK_BITS-1:0] hold_delay_q;
	logic [dphc_pkg::TICK_BITS-1:0] run_ticks_q;

	// Run state
	logic                           running_q;
	logic                           holding_q;
	logic [dphc_pkg::TICK_BITS-1:0] elapsed_q;
	logic [dphc_pkg::ADC_BITS-1:0]  baseline_q;
	logic [dphc_pkg::ADC_BITS-1:0]  target_q;
	logic [dphc_pkg::SDRV_W-1:0]    sdrv_q;

	// Current item and its result
	logic [dphc_pkg::CMD_W-1:0]     cmd_q;
	logic [dphc_pkg::ADC_BITS-1:0]  pos_q;
	logic [dphc_pkg::MODE_W-1:0]    mode_q;
	logic [dphc_pkg::DUTY_W-1:0]    duty_q;
	logic                           done_q;

	logic                           m_tvalid_q;
	logic [dphc_pkg::M_TDATA_W-1:0] m_tdata_q;

	// Decision and duty logic
	logic                           positive;
	logic [dphc_pkg::ADC_BITS-1:0]  mag;
	logic                           in_band;
	logic                           run_over;
	logic                           hold_now;
	logic [dphc_pkg::TICK_BITS-1:0] elapsed_next;
	logic                           div_start;
	logic                           div_done;
	logic [dphc_pkg::ADC_BITS-1:0]  quotient;
	logic [dphc_pkg::ADC_BITS:0]    duty_sum;
	logic [dphc_pkg::DUTY_W-1:0]    duty_clamp;
	logic [dphc_pkg::DUTY_W-1:0]    duty_final;
	logic                           out_free;

	always_comb begin
		positive = setpoint_q > pos_q;
		mag      = positive ? (setpoint_q - pos_q) : (pos_q - setpoint_q);
		in_band  = mag <= deadband_q;
		run_over = elapsed_q >= run_ticks_q;
		hold_now = holding_q || (elapsed_q >= hold_delay_q);
		// hold the count at its maximum
		elapsed_next = (elapsed_q == '1) ? elapsed_q
		                                 : elapsed_q + dphc_pkg::TICK_BITS'(1);
		div_start = (state_q == ST_DECIDE) && (cmd_q == dphc_pkg::CMD_TICK) &&
		            running_q && !run_over && hold_now && !in_band;

		// clamp to max_duty, then to the percent limit
		duty_sum = {{(dphc_pkg::ADC_BITS + 1 - dphc_pkg::DUTY_W){1'b0}}, min_duty_q} +
		           {1'b0, quotient};
		duty_clamp = (duty_sum > {{(dphc_pkg::ADC_BITS + 1 - dphc_pkg::DUTY_W){1'b0}},
		                          max_duty_q}) ? max_duty_q
		                                       : duty_sum[dphc_pkg::DUTY_W-1:0];
		duty_final = (duty_clamp > dphc_pkg::DUTY_LIMIT) ? dphc_pkg::DUTY_LIMIT
		                                                 : duty_clamp;

		out_free = !m_tvalid_q || m_tready;
	end

	dphc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (err_div_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= dphc_pkg::RST_SETPOINT;
			deadband_q   <= dphc_pkg::RST_DEADBAND;
			min_duty_q   <= dphc_pkg::RST_MIN_DUTY;
			max_duty_q   <= dphc_pkg::RST_MAX_DUTY;
			err_div_q    <= dphc_pkg::RST_ERR_DIV;
			hold_delay_q <= dphc_pkg::RST_HOLD_DELAY;
			run_ticks_q  <= dphc_pkg::RST_RUN_TICKS;
		end else if (cfg_we) begin
			case (cfg_index)
				dphc_pkg::REG_SETPOINT:   setpoint_q   <= cfg_data[dphc_pkg::ADC_BITS-1:0];
				dphc_pkg::REG_DEADBAND:   deadband_q   <= cfg_data[dphc_pkg::ADC_BITS-1:0];
				dphc_pkg::REG_MIN_DUTY:   min_duty_q   <= cfg_data[dphc_pkg::DUTY_W-1:0];
				dphc_pkg::REG_MAX_DUTY:   max_duty_q   <= cfg_data[dphc_pkg::DUTY_W-1:0];
				dphc_pkg::REG_ERR_DIV:    err_div_q    <= cfg_data[dphc_pkg::ADC_BITS-1:0];
				dphc_pkg::REG_HOLD_DELAY: hold_delay_q <= cfg_data[dphc_pkg::TICK_BITS-1:0];
				dphc_pkg::REG_RUN_TICKS:  run_ticks_q  <= cfg_data[dphc_pkg::TICK_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: state, run state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			running_q  <= 1'b0;
			holding_q  <= 1'b0;
			elapsed_q  <= '0;
			baseline_q <= '0;
			target_q   <= '0;
			sdrv_q     <= '0;
			cmd_q      <= dphc_pkg::CMD_TICK;
			pos_q      <= '0;
			mode_q     <= dphc_pkg::MODE_UNCHANGED;
			duty_q     <= '0;
			done_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// the finish step reloads the slot itself
			if (m_tvalid_q && m_tready && state_q != ST_FINISH) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						pos_q   <= s_tdata[dphc_pkg::ADC_BITS-1:0];
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					mode_q  <= dphc_pkg::MODE_UNCHANGED;
					duty_q  <= '0;
					done_q  <= 1'b0;
					state_q <= ST_FINISH;
					if (cmd_q == dphc_pkg::CMD_START) begin
						// restart the run from the measured position
						running_q  <= 1'b1;
						holding_q  <= 1'b0;
						elapsed_q  <= '0;
						baseline_q <= pos_q;
						target_q   <= pos_q;
						sdrv_q     <= '0;
						mode_q     <= dphc_pkg::MODE_COAST;
					end else if (cmd_q == dphc_pkg::CMD_STOP ||
					             (cmd_q == dphc_pkg::CMD_TICK && running_q && run_over)) begin
						// end the run and brake, also when no run was active
						running_q  <= 1'b0;
						holding_q  <= 1'b0;
						baseline_q <= pos_q;
						target_q   <= pos_q;
						sdrv_q     <= '0;
						mode_q     <= dphc_pkg::MODE_BRAKE;
						done_q     <= (cmd_q == dphc_pkg::CMD_TICK);
					end else if (cmd_q == dphc_pkg::CMD_TICK && running_q) begin
						holding_q <= hold_now;
						elapsed_q <= elapsed_next;
						if (!hold_now) begin
							target_q <= baseline_q;
							sdrv_q   <= '0;
							mode_q   <= dphc_pkg::MODE_COAST;
						end else if (in_band) begin
							target_q <= setpoint_q;
							sdrv_q   <= '0;
							mode_q   <= dphc_pkg::MODE_BRAKE;
						end else begin
							// drive: wait for the divider
							target_q <= setpoint_q;
							mode_q   <= positive ? dphc_pkg::MODE_FORWARD
							                     : dphc_pkg::MODE_REVERSE;
							state_q  <= ST_DIVIDE;
						end
					end
				end
				ST_DIVIDE: begin
					if (div_done) begin
						duty_q  <= duty_final;
						sdrv_q  <= positive ? {1'b0, duty_final}
						                    : (~{1'b0, duty_final}) + dphc_pkg::SDRV_W'(1);
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tdata_q  <= {done_q, running_q, target_q, sdrv_q, duty_q, mode_q};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[hw/rtl/dphc_checker.sv]
module dphc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [dphc_pkg::M_TDATA_W-1:0] m_tdata
);

	// a waiting result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// not ready in the cycle after taking an item
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after accept");

	// end of run by time brakes and leaves no run active
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31] |-> m_tdata[2:0] == dphc_pkg::MODE_BRAKE && !m_tdata[30])
		else $error("run_done without brake or with run active");

	// duty only in a driving mode
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != dphc_pkg::MODE_FORWARD &&
		m_tdata[2:0] != dphc_pkg::MODE_REVERSE |-> m_tdata[9:3] == '0)
		else $error("duty outside a driving mode");

	// coast and brake zero the signed drive
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == dphc_pkg::MODE_COAST ||
		m_tdata[2:0] == dphc_pkg::MODE_BRAKE) |-> m_tdata[17:10] == '0)
		else $error("signed drive nonzero on coast or brake");

endmodule

bind deadband_position_hold_controller dphc_checker u_dphc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[test/deadband_position_hold_controller_tb.sv]
module deadband_position_hold_controller_tb;

	// Command value that the block must ignore
	localparam logic [dphc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int RESET_CYCLES    = 10;
	localparam int SETTLE_CYCLES   = 24;
	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 92;     // counted on items offered
	localparam int LONG_HOLD       = 300;
	localparam int CYCLE_LIMIT     = 600000;

	// One result item, laid out exactly as m_tdata (highest field first)
	typedef struct packed {
		logic                          run_done;
		logic                          run_active;
		logic [dphc_pkg::ADC_BITS-1:0] target;
		logic [dphc_pkg::SDRV_W-1:0]   sdrv;
		logic [dphc_pkg::DUTY_W-1:0]   duty;
		logic [dphc_pkg::MODE_W-1:0]   mode;
	} drive_result_t;

	// One row of the directed stimulus: an item or a register write
	typedef struct packed {
		logic                           is_cfg;
		logic                           typed;     // exp holds a hand-written result
		logic [dphc_pkg::CMD_W-1:0]     cmd;
		logic [dphc_pkg::CFG_IDX_W-1:0] reg_idx;
		logic [15:0]                    value;     // position or register value
		drive_result_t                  exp;
	} stim_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [dphc_pkg::S_TDATA_W-1:0]  s_tdata;
	logic [dphc_pkg::CMD_W-1:0]      s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [dphc_pkg::M_TDATA_W-1:0]  m_tdata;
	logic                            cfg_we;
	logic [dphc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dphc_pkg::CFG_DATA_W-1:0] cfg_data;

	// Register copies kept alongside the block
	logic [dphc_pkg::ADC_BITS-1:0]  cfg_setpoint;
	logic [dphc_pkg::ADC_BITS-1:0]  cfg_deadband;
	logic [dphc_pkg::DUTY_W-1:0]    cfg_min_duty;
	logic [dphc_pkg::DUTY_W-1:0]    cfg_max_duty;
	logic [dphc_pkg::ADC_BITS-1:0]  cfg_err_div;
	logic [dphc_pkg::TICK_BITS-1:0] cfg_hold_delay;
	logic [dphc_pkg::TICK_BITS-1:0] cfg_run_ticks;

	// Controller state as the predictor tracks it
	logic                           ctl_running;
	logic                           ctl_holding;
	logic [dphc_pkg::TICK_BITS-1:0] ctl_elapsed;
	logic [dphc_pkg::ADC_BITS-1:0]  ctl_baseline;
	logic [dphc_pkg::ADC_BITS-1:0]  ctl_target;
	logic [dphc_pkg::SDRV_W-1:0]    ctl_sdrv;

	drive_result_t pending_results[$];
	stim_row_t     directed_steps[$];

	// Idling knobs, set per phase by the stimulus process
	bit feed_gaps;
	bit sink_gaps;
	int sink_hold_cycles;

	int error_count;
	int items_offered;
	int effective_items;
	int results_seen;
	int drive_results;
	int timed_ends;
	int reg_writes;
	int cycle_count;

	deadband_position_hold_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Drop the run: remember where the motor stopped and clear the drive.
	function automatic void close_run(input logic [dphc_pkg::ADC_BITS-1:0] pos);
		ctl_baseline = pos;
		ctl_target   = pos;
		ctl_sdrv     = '0;
		ctl_holding  = 1'b0;
		ctl_running  = 1'b0;
	endfunction

	// Advance the controller by one item and return the drive it commands.
	function automatic drive_result_t next_drive_result(
			input logic [dphc_pkg::CMD_W-1:0] cmd,
			input logic [dphc_pkg::ADC_BITS-1:0] pos);
		drive_result_t r;
		logic          fwd;
		int unsigned   mag;
		int unsigned   divisor;
		int unsigned   duty_calc;
		r = '0;
		r.mode = dphc_pkg::MODE_UNCHANGED;
		case (cmd)
			dphc_pkg::CMD_START: begin
				ctl_running  = 1'b1;
				ctl_holding  = 1'b0;
				ctl_elapsed  = '0;
				ctl_baseline = pos;
				ctl_target   = pos;
				ctl_sdrv     = '0;
				r.mode       = dphc_pkg::MODE_COAST;
			end
			dphc_pkg::CMD_STOP: begin
				close_run(pos);
				r.mode = dphc_pkg::MODE_BRAKE;
			end
			dphc_pkg::CMD_TICK: begin
				// an idle tick changes nothing
				if (ctl_running) begin
					if (ctl_elapsed >= cfg_run_ticks) begin
						close_run(pos);
						r.mode     = dphc_pkg::MODE_BRAKE;
						r.run_done = 1'b1;
					end else begin
						if (!ctl_holding && ctl_elapsed >= cfg_hold_delay)
							ctl_holding = 1'b1;
						if (!ctl_holding) begin
							ctl_target = ctl_baseline;
							ctl_sdrv   = '0;
							r.mode     = dphc_pkg::MODE_COAST;
						end else begin
							fwd        = cfg_setpoint > pos;
							mag        = fwd ? cfg_setpoint - pos : pos - cfg_setpoint;
							ctl_target = cfg_setpoint;
							if (mag <= cfg_deadband) begin
								ctl_sdrv = '0;
								r.mode   = dphc_pkg::MODE_BRAKE;
							end else begin
								divisor   = (cfg_err_div == 0) ? 1 : cfg_err_div;
								duty_calc = cfg_min_duty + mag / divisor;
								if (duty_calc > cfg_max_duty)
									duty_calc = cfg_max_duty;
								if (duty_calc > dphc_pkg::DUTY_LIMIT)
									duty_calc = dphc_pkg::DUTY_LIMIT;
								r.duty = duty_calc[dphc_pkg::DUTY_W-1:0];
								if (fwd) begin
									r.mode   = dphc_pkg::MODE_FORWARD;
									ctl_sdrv = duty_calc[dphc_pkg::SDRV_W-1:0];
								end else begin
									r.mode   = dphc_pkg::MODE_REVERSE;
									ctl_sdrv = 8'd0 - duty_calc[dphc_pkg::SDRV_W-1:0];
								end
							end
						end
						if (ctl_elapsed != '1)
							ctl_elapsed = ctl_elapsed + 1'b1;
					end
				end
			end
			default: ;    // unused command: no state change
		endcase
		r.sdrv       = ctl_sdrv;
		r.target     = ctl_target;
		r.run_active = ctl_running;
		return r;
	endfunction

	// Directed table builders
	function automatic void add_item(input logic [dphc_pkg::CMD_W-1:0] cmd, input int pos);
		stim_row_t row;
		row       = '0;
		row.cmd   = cmd;
		row.value = pos[15:0];
		directed_steps.push_back(row);
	endfunction

	function automatic void add_checked(input logic [dphc_pkg::CMD_W-1:0] cmd, input int pos,
			input logic [dphc_pkg::MODE_W-1:0] mode, input int duty, input int sdrv,
			input int target, input bit run_active, input bit run_done);
		stim_row_t row;
		row                = '0;
		row.cmd            = cmd;
		row.value          = pos[15:0];
		row.typed          = 1'b1;
		row.exp.mode       = mode;
		row.exp.duty       = duty[dphc_pkg::DUTY_W-1:0];
		row.exp.sdrv       = sdrv[dphc_pkg::SDRV_W-1:0];
		row.exp.target     = target[dphc_pkg::ADC_BITS-1:0];
		row.exp.run_active = run_active;
		row.exp.run_done   = run_done;
		directed_steps.push_back(row);
	endfunction

	function automatic void add_cfg(input logic [dphc_pkg::CFG_IDX_W-1:0] idx,
			input int value);
		stim_row_t row;
		row         = '0;
		row.is_cfg  = 1'b1;
		row.reg_idx = idx;
		row.value   = value[15:0];
		directed_steps.push_back(row);
	endfunction

	// Pick a position around the setpoint, clamped to the ADC range.
	function automatic logic [dphc_pkg::ADC_BITS-1:0] near_setpoint(input int span);
		int pos;
		pos = int'(cfg_setpoint) + int'($urandom_range(0, 2 * span)) - span;
		if (pos < 0)
			pos = 0;
		if (pos > 4095)
			pos = 4095;
		return pos[dphc_pkg::ADC_BITS-1:0];
	endfunction

	// Offer one item on the input side; called and left at a falling edge.
	task automatic offer_item(input logic [dphc_pkg::CMD_W-1:0] cmd,
			input logic [dphc_pkg::ADC_BITS-1:0] pos,
			input bit typed, input drive_result_t typed_exp);
		int            gap;
		drive_result_t predicted;
		gap = feed_gaps ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = {{(dphc_pkg::S_TDATA_W-dphc_pkg::ADC_BITS){1'b0}}, pos};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// Item accepted at this edge: advance the predictor.
		predicted = next_drive_result(cmd, pos);
		pending_results.push_back(typed ? typed_exp : predicted);
		items_offered++;
		if (predicted.mode != dphc_pkg::MODE_UNCHANGED)
			effective_items++;
		@(negedge clk);
	endtask

	// Stop offering, wait for every result, then let the block go quiet.
	task automatic settle_block();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write one register while the block is idle and track it.
	task automatic write_register(input logic [dphc_pkg::CFG_IDX_W-1:0] idx,
			input int unsigned value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value[dphc_pkg::CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
		reg_writes++;
		case (idx)
			dphc_pkg::REG_SETPOINT:   cfg_setpoint   = value[dphc_pkg::ADC_BITS-1:0];
			dphc_pkg::REG_DEADBAND:   cfg_deadband   = value[dphc_pkg::ADC_BITS-1:0];
			dphc_pkg::REG_MIN_DUTY:   cfg_min_duty   = value[dphc_pkg::DUTY_W-1:0];
			dphc_pkg::REG_MAX_DUTY:   cfg_max_duty   = value[dphc_pkg::DUTY_W-1:0];
			dphc_pkg::REG_ERR_DIV:    cfg_err_div    = value[dphc_pkg::ADC_BITS-1:0];
			dphc_pkg::REG_HOLD_DELAY: cfg_hold_delay = value[dphc_pkg::TICK_BITS-1:0];
			dphc_pkg::REG_RUN_TICKS:  cfg_run_ticks  = value[dphc_pkg::TICK_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Result side: draw a stall per item, and hold off for a long stretch on request.
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_cycles != 0) begin
				m_tready = 1'b0;
				repeat (sink_hold_cycles) @(negedge clk);
				sink_hold_cycles = 0;
			end
			stall = sink_gaps ? $urandom_range(0, 15) : 0;
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	// Check every accepted result against the oldest expectation.
	always @(posedge clk) begin : result_check
		drive_result_t want;
		drive_result_t got;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			results_seen++;
			if (got.mode == dphc_pkg::MODE_FORWARD || got.mode == dphc_pkg::MODE_REVERSE)
				drive_results++;
			if (got.run_done)
				timed_ends++;
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected: m_tdata %h", m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("drive_mode", want.mode, got.mode);
				compare_field("duty", want.duty, got.duty);
				compare_field("signed_drive", $signed(want.sdrv), $signed(got.sdrv));
				compare_field("target", want.target, got.target);
				compare_field("run_active", want.run_active, got.run_active);
				compare_field("run_done", want.run_done, got.run_done);
			end
		end
	end

	// Bound the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("deadband_position_hold_controller_tb: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		int          phase_goal;
		int          run_len;
		int          roll;
		int          span;
		bit          paused;
		logic [1:0]  noise_cmd;
		logic [11:0] noise_pos;
		logic [11:0] start_pos;

		// Known values on every input from time zero; hold reset.
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = dphc_pkg::CMD_TICK;
		cfg_we    = 1'b0;
		cfg_index = dphc_pkg::REG_SETPOINT;
		cfg_data  = '0;
		feed_gaps = 1'b0;
		sink_gaps = 1'b0;
		sink_hold_cycles = 0;
		paused = 1'b0;

		cfg_setpoint   = dphc_pkg::RST_SETPOINT;
		cfg_deadband   = dphc_pkg::RST_DEADBAND;
		cfg_min_duty   = dphc_pkg::RST_MIN_DUTY;
		cfg_max_duty   = dphc_pkg::RST_MAX_DUTY;
		cfg_err_div    = dphc_pkg::RST_ERR_DIV;
		cfg_hold_delay = dphc_pkg::RST_HOLD_DELAY;
		cfg_run_ticks  = dphc_pkg::RST_RUN_TICKS;
		ctl_running    = 1'b0;
		ctl_holding    = 1'b0;
		ctl_elapsed    = '0;
		ctl_baseline   = '0;
		ctl_target     = '0;
		ctl_sdrv       = '0;

		// Directed part. Reset settings first: idle tick, stop while idle,
		// a coasting run, the unused command in a run.
		add_checked(dphc_pkg::CMD_TICK, 0, dphc_pkg::MODE_UNCHANGED, 0, 0, 0, 0, 0);
		add_checked(dphc_pkg::CMD_STOP, 4095, dphc_pkg::MODE_BRAKE, 0, 0, 4095, 0, 0);
		add_checked(dphc_pkg::CMD_START, 0, dphc_pkg::MODE_COAST, 0, 0, 0, 1, 0);
		add_checked(dphc_pkg::CMD_TICK, 4095, dphc_pkg::MODE_COAST, 0, 0, 0, 1, 0);
		add_checked(CMD_UNUSED, 1234, dphc_pkg::MODE_UNCHANGED, 0, 0, 0, 1, 0);
		add_checked(dphc_pkg::CMD_STOP, 2047, dphc_pkg::MODE_BRAKE, 0, 0, 2047, 0, 0);
		// Short run: one coast tick, deadband edge, the max-duty clamp both ways, timed end.
		add_cfg(dphc_pkg::REG_HOLD_DELAY, 1);
		add_cfg(dphc_pkg::REG_RUN_TICKS, 5);
		add_checked(dphc_pkg::CMD_START, 2600, dphc_pkg::MODE_COAST, 0, 0, 2600, 1, 0);
		add_checked(dphc_pkg::CMD_TICK, 2600, dphc_pkg::MODE_COAST, 0, 0, 2600, 1, 0);
		add_checked(dphc_pkg::CMD_TICK, 2660, dphc_pkg::MODE_BRAKE, 0, 0, 2600, 1, 0);
		add_item(dphc_pkg::CMD_TICK, 2539);
		add_checked(dphc_pkg::CMD_TICK, 0, dphc_pkg::MODE_FORWARD, 60, 60, 2600, 1, 0);
		add_checked(dphc_pkg::CMD_TICK, 4095, dphc_pkg::MODE_REVERSE, 60, -60, 2600, 1, 0);
		add_checked(dphc_pkg::CMD_TICK, 100, dphc_pkg::MODE_BRAKE, 0, 0, 100, 0, 1);
		add_checked(dphc_pkg::CMD_TICK, 7, dphc_pkg::MODE_UNCHANGED, 0, 0, 100, 0, 0);
		// Zero divisor, min above max, zero deadband, top setpoint.
		add_cfg(dphc_pkg::REG_SETPOINT, 4095);
		add_cfg(dphc_pkg::REG_DEADBAND, 0);
		add_cfg(dphc_pkg::REG_MIN_DUTY, 100);
		add_cfg(dphc_pkg::REG_MAX_DUTY, 40);
		add_cfg(dphc_pkg::REG_ERR_DIV, 0);
		add_cfg(dphc_pkg::REG_HOLD_DELAY, 0);
		add_cfg(dphc_pkg::REG_RUN_TICKS, 3);
		add_checked(dphc_pkg::CMD_START, 4095, dphc_pkg::MODE_COAST, 0, 0, 4095, 1, 0);
		add_item(dphc_pkg::CMD_TICK, 4095);
		add_item(dphc_pkg::CMD_TICK, 4094);
		add_item(dphc_pkg::CMD_TICK, 0);
		add_item(dphc_pkg::CMD_TICK, 0);
		// Zero run length ends on the first tick.
		add_cfg(dphc_pkg::REG_SETPOINT, 0);
		add_cfg(dphc_pkg::REG_DEADBAND, 4095);
		add_cfg(dphc_pkg::REG_MIN_DUTY, 0);
		add_cfg(dphc_pkg::REG_MAX_DUTY, 100);
		add_cfg(dphc_pkg::REG_ERR_DIV, 4095);
		add_cfg(dphc_pkg::REG_RUN_TICKS, 0);
		add_checked(dphc_pkg::CMD_START, 5, dphc_pkg::MODE_COAST, 0, 0, 5, 1, 0);
		add_checked(dphc_pkg::CMD_TICK, 5, dphc_pkg::MODE_BRAKE, 0, 0, 5, 0, 1);
		// Longest timers, then full-scale reverse drive.
		add_cfg(dphc_pkg::REG_RUN_TICKS, 65535);
		add_cfg(dphc_pkg::REG_HOLD_DELAY, 65535);
		add_cfg(dphc_pkg::REG_DEADBAND, 0);
		add_cfg(dphc_pkg::REG_ERR_DIV, 1);
		add_item(dphc_pkg::CMD_START, 1);
		add_item(dphc_pkg::CMD_TICK, 4095);
		add_cfg(dphc_pkg::REG_HOLD_DELAY, 0);
		add_checked(dphc_pkg::CMD_TICK, 4095, dphc_pkg::MODE_REVERSE, 100, -100, 0, 1, 0);
		add_item(dphc_pkg::CMD_TICK, 0);
		add_checked(dphc_pkg::CMD_STOP, 3000, dphc_pkg::MODE_BRAKE, 0, 0, 3000, 0, 0);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table; register writes wait for the block to idle.
		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_cfg) begin
				settle_block();
				write_register(directed_steps[i].reg_idx, directed_steps[i].value);
			end else begin
				offer_item(directed_steps[i].cmd,
					directed_steps[i].value[dphc_pkg::ADC_BITS-1:0],
					directed_steps[i].typed, directed_steps[i].exp);
			end
		end

		// Random part: one register setting per phase, then runs of ticks.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle_block();
			if (ph == 0) begin
				write_register(dphc_pkg::REG_SETPOINT, 0);
				write_register(dphc_pkg::REG_DEADBAND, 0);
				write_register(dphc_pkg::REG_MIN_DUTY, 0);
				write_register(dphc_pkg::REG_MAX_DUTY, 100);
				write_register(dphc_pkg::REG_ERR_DIV, 1);
				write_register(dphc_pkg::REG_HOLD_DELAY, 0);
				write_register(dphc_pkg::REG_RUN_TICKS, 40);
			end else if (ph == 1) begin
				write_register(dphc_pkg::REG_SETPOINT, 4095);
				write_register(dphc_pkg::REG_DEADBAND, 4095);
				write_register(dphc_pkg::REG_MIN_DUTY, 100);
				write_register(dphc_pkg::REG_MAX_DUTY, 0);
				write_register(dphc_pkg::REG_ERR_DIV, 4095);
				write_register(dphc_pkg::REG_HOLD_DELAY, 3);
				write_register(dphc_pkg::REG_RUN_TICKS, 65535);
			end else begin
				roll = $urandom_range(0, 9);
				write_register(dphc_pkg::REG_SETPOINT, (roll == 0) ? 0 : (roll == 1) ? 4095 :
					$urandom_range(0, 4095));
				roll = $urandom_range(0, 9);
				write_register(dphc_pkg::REG_DEADBAND, (roll < 2) ? 0 : (roll == 2) ?
					$urandom_range(0, 4095) : $urandom_range(0, 200));
				write_register(dphc_pkg::REG_MIN_DUTY, $urandom_range(0, 100));
				write_register(dphc_pkg::REG_MAX_DUTY, $urandom_range(0, 100));
				roll = $urandom_range(0, 9);
				write_register(dphc_pkg::REG_ERR_DIV, (roll < 6) ? $urandom_range(1, 64) :
					$urandom_range(1, 4095));
				roll = $urandom_range(0, 9);
				write_register(dphc_pkg::REG_HOLD_DELAY, (roll < 2) ? 0 : (roll == 2) ?
					$urandom_range(0, 65535) : $urandom_range(0, 20));
				roll = $urandom_range(0, 9);
				write_register(dphc_pkg::REG_RUN_TICKS, (roll == 0) ? 0 : (roll < 3) ?
					$urandom_range(100, 65535) : $urandom_range(1, 60));
			end

			// Phases cycle through no idling, sender gaps, receiver stalls, both.
			feed_gaps = (ph % 4 == 1) || (ph % 4 == 3);
			sink_gaps = (ph % 4 == 2) || (ph % 4 == 3);
			if (ph == 4) begin
				// Back-to-back items into a receiver that holds off: the block fills.
				feed_gaps = 1'b0;
				sink_hold_cycles = LONG_HOLD;
			end

			phase_goal = items_offered + ITEMS_PER_PHASE;
			while (items_offered < phase_goal) begin
				if ($urandom_range(0, 99) < 12) begin
					// Noise: any command, any position
					noise_cmd = 2'($urandom_range(0, 3));
					noise_pos = 12'($urandom_range(0, 4095));
					offer_item(noise_cmd, noise_pos, 1'b0, '0);
				end else begin
					start_pos = ($urandom_range(0, 1) != 0) ? near_setpoint(400) :
						12'($urandom_range(0, 4095));
					offer_item(dphc_pkg::CMD_START, start_pos, 1'b0, '0);
					run_len = $urandom_range(1, 40);
					for (int k = 0; k < run_len; k++) begin
						roll = $urandom_range(0, 99);
						noise_pos = 12'($urandom_range(0, 4095));
						span = ($urandom_range(0, 1) != 0) ? int'(cfg_deadband) + 16 : 600;
						if (roll < 3)
							offer_item(dphc_pkg::CMD_STOP, noise_pos, 1'b0, '0);
						else if (roll < 6)
							offer_item(CMD_UNUSED, noise_pos, 1'b0, '0);
						else if (roll < 26)
							offer_item(dphc_pkg::CMD_TICK, noise_pos, 1'b0, '0);
						else
							offer_item(dphc_pkg::CMD_TICK, near_setpoint(span), 1'b0, '0);
					end
				end
				// Once, pause the sender midway until everything has drained.
				if (ph == 7 && !paused &&
				    items_offered >= phase_goal - ITEMS_PER_PHASE / 2) begin
					settle_block();
					paused = 1'b1;
				end
			end
		end

		settle_block();

		$display("covered %0d items (%0d acting), %0d results checked, %0d register writes",
			items_offered, effective_items, results_seen, reg_writes);
		$display("drive results %0d, runs ended by time %0d, mismatches %0d",
			drive_results, timed_ends, error_count);
		if (error_count == 0)
			$display("deadband_position_hold_controller_tb: done, clean");
		else
			$display("deadband_position_hold_controller_tb: done, errors");
		$finish;
	end

endmodule
